@@ hw/rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and shared types.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [31:0] word;
      logic        first;
      logic        fin;
   } beat_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
   };

   localparam word_type INIT_H [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
   };

endpackage

@@ hw/rtl/sha_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front end
// Takes message beats, counts length and emits padded 32-bit block words.
// ----------------------------------------------------------------------------
module sha_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [31:0]       req_data_word,
   input  logic [2:0]        req_byte_count,
   input  logic              req_last,
   output logic              wq_push,
   input  logic              wq_full,
   output sha_pkg::beat_type wq_beat
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXTRA = 4'b0010,
      ST_ZERO  = 4'b0100,
      ST_LEN   = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  fill_ff, fill_in;
   logic [63:0] bytes_ff, bytes_in;
   logic        hi_ff, hi_in;
   logic        first_ff, first_in;
   logic [2:0]  cnt;
   logic [31:0] mask, padw, bits_hi, bits_lo;
   logic [63:0] bits;

   always_comb begin
      cnt = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
      case (cnt)
         3'd0:    begin mask = 32'h0;        padw = {sha_pkg::PAD_BYTE, 24'h0}; end
         3'd1:    begin mask = 32'hff000000; padw = {8'h0, sha_pkg::PAD_BYTE, 16'h0}; end
         3'd2:    begin mask = 32'hffff0000; padw = {16'h0, sha_pkg::PAD_BYTE, 8'h0}; end
         3'd3:    begin mask = 32'hffffff00; padw = {24'h0, sha_pkg::PAD_BYTE}; end
         default: begin mask = 32'hffffffff; padw = 32'h0; end
      endcase
   end

   assign bits    = {bytes_ff[60:0], 3'b000};
   assign bits_hi = bits[63:32];
   assign bits_lo = bits[31:0];
   assign req_full = (state_ff != ST_IDLE) || wq_full;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      hi_in    = hi_ff;
      first_in = first_ff;
      wq_push  = 1'b0;
      wq_beat  = '{word: 32'h0, first: first_ff, fin: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_push && !wq_full) begin
               wq_push = 1'b1;
               fill_in = fill_ff + 4'd1;
               first_in = 1'b0;
               if (!req_last) begin
                  wq_beat.word = req_data_word;
                  bytes_in = bytes_ff + 64'd4;
               end else begin
                  wq_beat.word = (req_data_word & mask) | padw;
                  bytes_in = bytes_ff + {61'h0, cnt};
                  if (cnt == 3'd4) state_in = ST_EXTRA;
                  else if (fill_ff == 4'd13) begin
                     state_in = ST_LEN;
                     hi_in = 1'b1;
                  end else state_in = ST_ZERO;
               end
            end
         end
         ST_EXTRA: begin
            if (!wq_full) begin
               wq_push = 1'b1;
               wq_beat.word = {sha_pkg::PAD_BYTE, 24'h0};
               fill_in = fill_ff + 4'd1;
               if (fill_ff == 4'd13) begin
                  state_in = ST_LEN;
                  hi_in = 1'b1;
               end else state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (!wq_full) begin
               wq_push = 1'b1;
               fill_in = fill_ff + 4'd1;
               if (fill_ff == 4'd13) begin
                  state_in = ST_LEN;
                  hi_in = 1'b1;
               end
            end
         end
         ST_LEN: begin
            if (!wq_full) begin
               wq_push = 1'b1;
               fill_in = fill_ff + 4'd1;
               wq_beat.word = hi_ff ? bits_hi : bits_lo;
               hi_in = 1'b0;
               if (!hi_ff) begin
                  wq_beat.fin = 1'b1;
                  state_in = ST_IDLE;
                  bytes_in = 64'h0;
                  fill_in  = 4'd0;
                  first_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= 4'd0;
         bytes_ff <= 64'h0;
         hi_ff    <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
         hi_ff    <= hi_in;
         first_ff <= first_in;
      end
   end

   a_len_at_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN && hi_ff) |-> fill_ff == 4'd14) else $error("len misplaced");
   a_fin_resets: assert property (@(posedge clock) disable iff (reset)
      (wq_push && wq_beat.fin) |=> (fill_ff == 4'd0 && bytes_ff == 64'h0))
      else $error("fin not cleared");
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_full) else $error("accepting while padding");

endmodule

@@ hw/rtl/sha_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Four-entry queue between front end and compression core.
// ----------------------------------------------------------------------------
module sha_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sha_pkg::beat_type din,
   input  logic              pop,
   output logic              empty,
   output sha_pkg::beat_type dout
);

   sha_pkg::beat_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full  = cnt_ff[2];
   assign empty = (cnt_ff == 3'd0);
   assign dout  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 2'd0;
         rp_ff <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (push && !full) wp_ff <= wp_ff + 2'd1;
         if (pop && !empty) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b0, push && !full} - {2'b0, pop && !empty};
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4) else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) == cnt_ff[1:0]) else $error("queue pointers diverge");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (empty && !push) |=> empty) else $error("queue filled without push");

endmodule

@@ hw/rtl/sha_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Loads 16 words, runs 64 rounds at one per cycle, holds the digest.
// ----------------------------------------------------------------------------
module sha_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              wq_empty,
   output logic              wq_pop,
   input  sha_pkg::beat_type wq_beat,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [63:0]       rsp_digest_top,
   output logic [63:0]       rsp_digest_upper_mid,
   output logic [63:0]       rsp_digest_lower_mid,
   output logic [63:0]       rsp_digest_bottom
);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_ROUND = 3'b010,
      ST_ADD   = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8];
   logic [31:0] dig_ff [8];
   logic [31:0] v_ff [8];
   logic [3:0]  wcnt_ff;
   logic [5:0]  rnd_ff;
   logic        fin_ff, first_ff;
   logic        out_v_ff;
   logic [31:0] s0, s1, wnew, t1, t2, e, a, wt;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   assign wq_pop = (state_ff == ST_LOAD) && !wq_empty && !(wq_beat.fin && out_v_ff);
   assign rsp_empty = !out_v_ff;

   assign s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign wnew = w_ff[0] + s0 + w_ff[9] + s1;
   assign wt = w_ff[0];
   assign e = v_ff[4];
   assign a = v_ff[0];
   assign t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_ff[5]) ^ (~e & v_ff[6])) + sha_pkg::ROUND_K[rnd_ff] + wt;
   assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (wq_pop && wcnt_ff == 4'd15) state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_ADD;
         ST_ADD:   state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && wq_pop) begin
         w_ff[wcnt_ff] <= wq_beat.word;
         if (wcnt_ff == 4'd0) begin
            first_ff <= wq_beat.first;
            for (int i = 0; i < 8; i++)
               v_ff[i] <= wq_beat.first ? sha_pkg::INIT_H[i] : h_ff[i];
         end
         fin_ff <= wq_beat.fin;
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (state_ff == ST_ADD) begin
         for (int i = 0; i < 8; i++)
            h_ff[i] <= (first_ff ? sha_pkg::INIT_H[i] : h_ff[i]) + v_ff[i];
      end
      // final block result is parked so later blocks can run under it
      if (state_ff == ST_ADD && fin_ff) begin
         for (int i = 0; i < 8; i++)
            dig_ff[i] <= (first_ff ? sha_pkg::INIT_H[i] : h_ff[i]) + v_ff[i];
      end
   end

   assign rsp_digest_top       = {dig_ff[0], dig_ff[1]};
   assign rsp_digest_upper_mid = {dig_ff[2], dig_ff[3]};
   assign rsp_digest_lower_mid = {dig_ff[4], dig_ff[5]};
   assign rsp_digest_bottom    = {dig_ff[6], dig_ff[7]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         wcnt_ff  <= 4'd0;
         rnd_ff   <= 6'd0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wq_pop) wcnt_ff <= wcnt_ff + 4'd1;
         if (state_ff == ST_ROUND) rnd_ff <= rnd_ff + 6'd1;
         if (state_ff == ST_ADD && fin_ff) out_v_ff <= 1'b1;
         else if (rsp_pop && out_v_ff) out_v_ff <= 1'b0;
      end
   end

   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> state_ff == ST_ADD)
      else $error("round count lost");
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> wcnt_ff == 4'd0) else $error("load count off");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_pop) |=> $stable(rsp_digest_top)) else $error("digest changed");

endmodule

@@ hw/rtl/sha256_message_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streams big-endian words into SHA-256 and returns one 256-bit digest per message.
// ----------------------------------------------------------------------------
// Input: push a beat while full is low. byte_count counts only with last.
// The front end pads the message and writes block words into a four-deep
// queue; the core loads 16 words, then runs 64 rounds at one per cycle plus
// a hash add step, so sustained throughput is bounded by the round loop.
// After last the front end inserts pad and length words, one per cycle while the queue has room.
// The digest shows up after the rounds and hash add of the final block and sits
// on rsp_ ports while rsp_empty is low; it leaves at the pop beat.
// If the receiver stalls, the next message is loaded and compressed until
// its final block, which waits for the held digest to be taken.
// Reset clears counters and control state; the next beat starts a new message.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_digest_top,
   output logic [63:0] rsp_digest_upper_mid,
   output logic [63:0] rsp_digest_lower_mid,
   output logic [63:0] rsp_digest_bottom
);

   logic wq_push, wq_full, wq_pop, wq_empty;
   sha_pkg::beat_type wq_din, wq_dout;

   sha_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data_word, .req_byte_count,
      .req_last, .wq_push, .wq_full, .wq_beat(wq_din)
   );

   sha_fifo u_fifo (
      .clock, .reset, .push(wq_push), .full(wq_full), .din(wq_din),
      .pop(wq_pop), .empty(wq_empty), .dout(wq_dout)
   );

   sha_core u_core (
      .clock, .reset, .wq_empty, .wq_pop, .wq_beat(wq_dout), .rsp_empty, .rsp_pop,
      .rsp_digest_top, .rsp_digest_upper_mid, .rsp_digest_lower_mid,
      .rsp_digest_bottom
   );

endmodule

@@ test/sha256_message_hasher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams directed and random messages through the hasher, predicts each
// digest with a behavioral SHA-256 model and checks every popped digest in
// order, with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sha256_message_hasher_tb;

   class digest_scoreboard;
      sha_pkg::word_type hash_state [8];
      sha_pkg::word_type block_buf [16];
      int         fill;
      logic [63:0] byte_total;
      logic [255:0] pending [$];
      int         errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::INIT_H[i];
         fill = 0;
         byte_total = '0;
      endfunction

      function sha_pkg::word_type rotr(sha_pkg::word_type x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress_block();
         sha_pkg::word_type w [64];
         sha_pkg::word_type v [8];
         sha_pkg::word_type s0, s1, t1, t2;
         for (int t = 0; t < 16; t++) w[t] = block_buf[t];
         for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
         end
         for (int t = 0; t < 8; t++) v[t] = hash_state[t];
         for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int t = 0; t < 8; t++) hash_state[t] += v[t];
      endfunction

      function void append_word(sha_pkg::word_type w);
         block_buf[fill] = w;
         fill++;
         if (fill == 16) begin
            compress_block();
            fill = 0;
         end
      endfunction

      function void note_beat(sha_pkg::word_type data, logic [2:0] count, logic last);
         int n;
         sha_pkg::word_type mask, pad;
         logic [63:0] bits;
         if (!last) begin
            byte_total += 4;
            append_word(data);
            return;
         end
         n = (count > 4) ? 4 : count;
         byte_total += n;
         mask = (n == 0) ? 32'h0 : ~(32'hffffffff >> (8 * n));
         pad = (n == 4) ? 32'h0 : (32'(sha_pkg::PAD_BYTE) << (24 - 8 * n));
         append_word((data & mask) | pad);
         if (n == 4) append_word({sha_pkg::PAD_BYTE, 24'h0});
         if (fill > 14) while (fill != 0) append_word('0);
         while (fill < 14) append_word('0);
         bits = byte_total << 3;
         append_word(bits[63:32]);
         append_word(bits[31:0]);
         pending.push_back({hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                            hash_state[4], hash_state[5], hash_state[6], hash_state[7]});
         restart();
      endfunction

      function void check_digest(logic [255:0] got);
         logic [255:0] exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected digest %h", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         for (int k = 0; k < 4; k++)
            if (got[255-64*k -: 64] !== exp[255-64*k -: 64]) begin
               $display("%0t: digest part %0d expected %h actual %h", $time, k,
                        exp[255-64*k -: 64], got[255-64*k -: 64]);
               errors++;
            end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [63:0] rsp_digest_top, rsp_digest_upper_mid, rsp_digest_lower_mid;
   logic [63:0] rsp_digest_bottom;

   digest_scoreboard board = new();
   int send_idle_pct = 8;
   int recv_idle_pct = 50;
   int hold_cycles = 0;

   sha256_message_hasher dut (.*);

   always #5 clock = ~clock;

   // push stays high after an accepted beat until the next call drives it
   task automatic send_beat(sha_pkg::word_type data, logic [2:0] count, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_data_word <= data;
      req_byte_count <= count;
      req_last <= last;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      board.note_beat(data, count, last);
      @(negedge clock);
   endtask

   task automatic send_message(int words, logic [2:0] count, bit random_count_mid);
      for (int i = 0; i < words; i++)
         send_beat($urandom(), random_count_mid ? 3'($urandom_range(7)) : 3'd0, 0);
      send_beat($urandom(), count, 1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_digest({rsp_digest_top, rsp_digest_upper_mid,
                             rsp_digest_lower_mid, rsp_digest_bottom});
   end

   always @(negedge clock) begin
      if (reset) rsp_pop <= 0;
      else if (hold_cycles > 0) begin
         rsp_pop <= 0;
         hold_cycles <= hold_cycles - 1;
      end else rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty, every byte count, above-four counts, boundary lengths
      send_beat(32'hffffffff, 3'd0, 1);
      for (int c = 0; c < 8; c++) send_beat(32'hffffffff, 3'(c), 1);
      send_beat(32'h00000000, 3'd4, 1);
      send_message(13, 3'd4, 1);
      send_message(13, 3'd3, 0);
      send_message(14, 3'd0, 0);
      send_message(15, 3'd2, 1);
      send_message(15, 3'd0, 0);
      send_beat(32'h61626300, 3'd3, 1);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 50 : 0;
         recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 8 : 0;
         if (phase == 2) hold_cycles = 3000;
         for (int m = 0; m < 50; m++) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
            send_message(len, 3'($urandom_range(7)), $urandom_range(1));
         end
      end
      req_push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
